// ===== rtl/sorted_value_count_table_assert.svh =====
// Assertion macros for the sorted value count table.
`ifndef SORTED_VALUE_COUNT_TABLE_ASSERT_SVH
`define SORTED_VALUE_COUNT_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SVCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svct assertion failed");

// Check that cons holds in the cycle after ante.
`define SVCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svct assertion failed");

`endif

// ===== rtl/svct_pkg.sv =====
`default_nettype none
package svct_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 8;
  localparam int POS_W    = 8;
  localparam int USED_W   = 9;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef struct packed {
    logic [0:0]        kind;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_value;
    logic [DATA_W-1:0] entry_count;
    logic [USED_W-1:0] used_entries;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    RA_MID   = 2'd0,
    RA_SLOT  = 2'd1,
    RA_PREV  = 2'd2,
    RA_INDEX = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_HIT   = 3'd1,
    EMIT_INS   = 3'd2,
    EMIT_FULL  = 3'd3,
    EMIT_RD    = 3'd4,
    EMIT_RANGE = 3'd5
  } emit_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    search_step;
    logic    count_wr;
    logic    init_k;
    logic    shift_wr;
    emit_t   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic slot_lt_used;
    logic mid_below;
    logic hit;
    logic full;
    logic k_gt_slot;
    logic idx_ok;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/svct_ctrl.sv =====
`default_nettype none
module svct_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 in_kind,
  input  wire svct_pkg::dp_stat_t stat,
  output svct_pkg::dp_cmd_t   cmd,
  output logic                busy
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD_CHK = 9'b000000010,
    S_RD_OUT = 9'b000000100,
    S_SRCH   = 9'b000001000,
    S_SCMP   = 9'b000010000,
    S_CHK    = 9'b000100000,
    S_MISS   = 9'b001000000,
    S_SHIFT  = 9'b010000000,
    S_SHWR   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd.load        = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.rd_sel      = svct_pkg::RA_MID;
    cmd.search_step = 1'b0;
    cmd.count_wr    = 1'b0;
    cmd.init_k      = 1'b0;
    cmd.shift_wr    = 1'b0;
    cmd.emit        = svct_pkg::EMIT_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_kind == svct_pkg::KIND_READ) begin
            state_nxt = S_RD_CHK;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_RD_CHK: begin
        if (stat.idx_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = svct_pkg::RA_INDEX;
          state_nxt  = S_RD_OUT;
        end else begin
          cmd.emit  = svct_pkg::EMIT_RANGE;
          state_nxt = S_IDLE;
        end
      end
      S_RD_OUT: begin
        cmd.emit  = svct_pkg::EMIT_RD;
        state_nxt = S_IDLE;
      end
      S_SRCH: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = svct_pkg::RA_MID;
          state_nxt  = S_SCMP;
        end else if (stat.slot_lt_used) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = svct_pkg::RA_SLOT;
          state_nxt  = S_CHK;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_SCMP: begin
        cmd.search_step = 1'b1;
        state_nxt       = S_SRCH;
      end
      S_CHK: begin
        if (stat.hit) begin
          cmd.count_wr = 1'b1;
          cmd.emit     = svct_pkg::EMIT_HIT;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (stat.full) begin
          cmd.emit  = svct_pkg::EMIT_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd.init_k = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.k_gt_slot) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = svct_pkg::RA_PREV;
          state_nxt  = S_SHWR;
        end else begin
          cmd.emit  = svct_pkg::EMIT_INS;
          state_nxt = S_IDLE;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/svct_datapath.sv =====
`default_nettype none
module svct_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire svct_pkg::in_item_t in_item,
  input  wire svct_pkg::dp_cmd_t  cmd,
  output svct_pkg::dp_stat_t   stat,
  output logic                 out_strobe,
  output svct_pkg::out_item_t  out_item
);

  localparam int ADDR_W = svct_pkg::ADDR_W;
  localparam int CNT_W  = svct_pkg::CNT_W;
  localparam int CMP_W  = svct_pkg::CMP_W;
  localparam int DATA_W = svct_pkg::DATA_W;

  svct_pkg::entry_t mem [svct_pkg::CAPACITY];
  svct_pkg::entry_t rd_data_r;

  logic [DATA_W-1:0]          value_r;
  logic [svct_pkg::IDX_W-1:0] index_r;
  logic [CNT_W-1:0]           used_r;
  logic [CNT_W-1:0]           used_nxt;
  logic [CNT_W-1:0]           lo_r;
  logic [CNT_W-1:0]           lo_nxt;
  logic [CNT_W-1:0]           hi_r;
  logic [CNT_W-1:0]           hi_nxt;
  logic [CNT_W-1:0]           k_r;
  logic [CNT_W-1:0]           k_nxt;
  logic                       out_strobe_r;
  logic                       out_strobe_nxt;
  svct_pkg::out_item_t        out_item_r;
  svct_pkg::out_item_t        out_item_nxt;

  logic [CNT_W:0]             mid_sum;
  logic [ADDR_W-1:0]          mid;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  svct_pkg::entry_t           wr_data;
  logic [DATA_W-1:0]          count_inc;

  assign mid_sum   = (CNT_W + 1)'(lo_r) + (CNT_W + 1)'(hi_r);
  assign mid       = ADDR_W'(mid_sum >> 1);
  assign count_inc = (rd_data_r.count == '1) ? rd_data_r.count : rd_data_r.count + 1'b1;

  always_comb begin
    unique case (cmd.rd_sel)
      svct_pkg::RA_MID:   rd_addr = mid;
      svct_pkg::RA_SLOT:  rd_addr = ADDR_W'(lo_r);
      svct_pkg::RA_PREV:  rd_addr = ADDR_W'(k_r - 1'b1);
      svct_pkg::RA_INDEX: rd_addr = ADDR_W'(index_r);
      default:            rd_addr = mid;
    endcase
  end

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = ADDR_W'(lo_r);
    wr_data.value = value_r;
    wr_data.count = count_inc;
    priority if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(k_r);
      wr_data = rd_data_r;
    end else if (cmd.count_wr) begin
      wr_en = 1'b1;
    end else if (cmd.emit == svct_pkg::EMIT_INS) begin
      wr_en         = 1'b1;
      wr_data.count = DATA_W'(1);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    k_nxt  = k_r;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = used_r;
    end else if (cmd.search_step) begin
      if (stat.mid_below) begin
        lo_nxt = CNT_W'(mid) + 1'b1;
      end else begin
        hi_nxt = CNT_W'(mid);
      end
    end
    if (cmd.init_k) begin
      k_nxt = used_r;
    end else if (cmd.shift_wr) begin
      k_nxt = k_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    k_r  <= k_nxt;
    if (cmd.load) begin
      value_r <= in_item.value;
      index_r <= in_item.index;
    end
  end

  assign used_nxt = (cmd.emit == svct_pkg::EMIT_INS) ? used_r + 1'b1 : used_r;

  always_comb begin
    out_strobe_nxt            = (cmd.emit != svct_pkg::EMIT_NONE);
    out_item_nxt.status       = svct_pkg::STATUS_OK;
    out_item_nxt.position     = '0;
    out_item_nxt.entry_value  = '0;
    out_item_nxt.entry_count  = '0;
    out_item_nxt.used_entries = svct_pkg::USED_W'(used_nxt);
    unique case (cmd.emit)
      svct_pkg::EMIT_HIT: begin
        out_item_nxt.position    = svct_pkg::POS_W'(lo_r);
        out_item_nxt.entry_value = value_r;
        out_item_nxt.entry_count = count_inc;
      end
      svct_pkg::EMIT_INS: begin
        out_item_nxt.position    = svct_pkg::POS_W'(lo_r);
        out_item_nxt.entry_value = value_r;
        out_item_nxt.entry_count = DATA_W'(1);
      end
      svct_pkg::EMIT_FULL: begin
        out_item_nxt.status = svct_pkg::STATUS_FULL;
      end
      svct_pkg::EMIT_RD: begin
        out_item_nxt.position    = svct_pkg::POS_W'(index_r);
        out_item_nxt.entry_value = rd_data_r.value;
        out_item_nxt.entry_count = rd_data_r.count;
      end
      svct_pkg::EMIT_RANGE: begin
        out_item_nxt.status = svct_pkg::STATUS_RANGE;
      end
      default: begin
        out_item_nxt.status = svct_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_strobe_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign stat.lo_lt_hi     = (lo_r < hi_r);
  assign stat.slot_lt_used = (lo_r < used_r);
  assign stat.mid_below    = (rd_data_r.value < value_r);
  assign stat.hit          = (rd_data_r.value == value_r);
  assign stat.full         = (used_r == CNT_W'(svct_pkg::CAPACITY));
  assign stat.k_gt_slot    = (k_r > lo_r);
  assign stat.idx_ok       = (CMP_W'(index_r) < CMP_W'(used_r));

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

// ===== rtl/sorted_value_count_table.sv =====
// Channel   Ports                      Handshake
// input     in_item                    start high, busy low at the clock edge
// result    out_item                   out_strobe high for one cycle
//
// Read: an index out of range is refused without a memory read; one in range reads its entry first.
// Add: binary search over one memory read port, one read per halving of the
// used range, then a check of the found slot, a read and a write for each
// larger entry moved up one place, and a write of the new entry.
// Reset clears the entry count; the table memory holds no reset value.
// Results cannot be stalled; busy stays high until the result is issued.
`default_nettype none
`include "sorted_value_count_table_assert.svh"
module sorted_value_count_table (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire svct_pkg::in_item_t in_item,
  output logic                 out_strobe,
  output svct_pkg::out_item_t  out_item
);

  svct_pkg::dp_cmd_t  cmd;
  svct_pkg::dp_stat_t stat;

  svct_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind[0]),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  svct_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  `SVCT_ASSERT_NEXT(a_no_strobe_after_accept, clk, rst_n, start && !busy, !out_strobe)
  `SVCT_ASSERT_SAME(a_strobe_after_busy, clk, rst_n, out_strobe, $past(busy))
  `SVCT_ASSERT_SAME(a_idle_on_strobe, clk, rst_n, out_strobe, !busy)
  `SVCT_ASSERT_SAME(a_empty_on_error, clk, rst_n,
    out_strobe && (out_item.status != svct_pkg::STATUS_OK), out_item.entry_count == '0)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svct_pkg::*;

  localparam int ITEMS = 1500;
  localparam int DRAIN_CYCLES = 600;

  class count_table_scoreboard;
    logic [DATA_W-1:0] held_values [CAPACITY];
    logic [DATA_W-1:0] held_counts [CAPACITY];
    int unsigned held;
    out_item_t pending_results [$];
    int failures;
    int inserts;
    int increments;
    int refusals;
    int reads;
    int misses;

    function new();
      held = 0;
      failures = 0;
      inserts = 0;
      increments = 0;
      refusals = 0;
      reads = 0;
      misses = 0;
    endfunction

    function int unsigned entries();
      return held;
    endfunction

    function logic [DATA_W-1:0] value_at(int unsigned pos);
      return held_values[pos];
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function out_item_t predict_entry(in_item_t it);
      out_item_t r;
      int unsigned slot;
      r = '0;
      if (it.kind == KIND_READ) begin
        if (it.index >= held) begin
          r.status = STATUS_RANGE;
          misses++;
        end else begin
          r.status = STATUS_OK;
          r.position = it.index;
          r.entry_value = held_values[it.index];
          r.entry_count = held_counts[it.index];
          reads++;
        end
      end else begin
        slot = held;
        for (int k = int'(held) - 1; k >= 0; k--) begin
          if (it.value <= held_values[k]) slot = k;
        end
        if (slot < held && held_values[slot] == it.value) begin
          if (held_counts[slot] != '1) held_counts[slot] = held_counts[slot] + 1;
          r.status = STATUS_OK;
          r.position = slot[POS_W-1:0];
          r.entry_value = it.value;
          r.entry_count = held_counts[slot];
          increments++;
        end else if (held >= CAPACITY) begin
          r.status = STATUS_FULL;
          refusals++;
        end else begin
          for (int k = int'(held); k > int'(slot); k--) begin
            held_values[k] = held_values[k-1];
            held_counts[k] = held_counts[k-1];
          end
          held_values[slot] = it.value;
          held_counts[slot] = 1;
          held++;
          r.status = STATUS_OK;
          r.position = slot[POS_W-1:0];
          r.entry_value = it.value;
          r.entry_count = 1;
          inserts++;
        end
      end
      r.used_entries = held[USED_W-1:0];
      return r;
    endfunction

    function void note_accepted(in_item_t it);
      pending_results.push_back(predict_entry(it));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending: status %0h position %0h",
               got.status, got.position);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("position", want.position, got.position);
      compare_field("entry_value", want.entry_value, got.entry_value);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("used_entries", want.used_entries, got.used_entries);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  count_table_scoreboard sb = new();
  logic [DATA_W-1:0] common_vals [32];
  bit no_idle;
  int sent;

  sorted_value_count_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) sb.check_result(out_item);
      if (start && busy === 1'b0) sb.note_accepted(in_item);
    end
  end

  function automatic in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t add_item(logic [DATA_W-1:0] v);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_ADD;
    it.value = v;
    return it;
  endfunction

  function automatic in_item_t read_item(int unsigned idx);
    in_item_t it;
    it = noise_item();
    it.kind = KIND_READ;
    it.index = (idx > 255) ? 8'd255 : idx[IDX_W-1:0];
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_item <= noise_item();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
  endtask

  initial begin
    int r;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    no_idle = 1'b0;
    sent = 0;
    common_vals[0] = '0;
    common_vals[1] = '1;
    for (int i = 2; i < 32; i++) common_vals[i] = $urandom;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_item(read_item(0));
    send_item(read_item(255));
    send_item(add_item(32'h0000_0000));
    send_item(add_item(32'hFFFF_FFFF));
    send_item(add_item(32'h8000_0000));
    send_item(add_item(32'h0000_0000));
    send_item(add_item(32'hFFFF_FFFF));
    send_item(add_item(32'h0000_0001));
    send_item(add_item(32'hFFFF_FFFE));
    send_item(add_item(32'h8000_0000));
    for (int i = 0; i < 7; i++) send_item(read_item(i));
    send_item(read_item(255));

    repeat (400) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        if ($urandom_range(0, 9) < 7) send_item(read_item($urandom_range(0, sb.entries() + 2)));
        else send_item(read_item($urandom_range(0, 255)));
      end else if (r < 75) begin
        send_item(add_item(common_vals[$urandom_range(0, 31)]));
      end else begin
        send_item(add_item($urandom));
      end
    end

    while (sb.entries() < CAPACITY) begin
      if ($urandom_range(0, 4) == 0) send_item(read_item($urandom_range(0, 255)));
      else send_item(add_item($urandom));
    end

    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_item(add_item($urandom));
      else if (r < 60) send_item(add_item(sb.value_at($urandom_range(0, sb.entries() - 1))));
      else send_item(read_item($urandom_range(0, 255)));
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d inserts, %0d count increments, %0d full refusals",
             sent, sb.inserts, sb.increments, sb.refusals);
    $display("Reads: %0d in range, %0d out of range; table held %0d entries at the end",
             sb.reads, sb.misses, sb.entries());
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
